// ===== hw/rtl/bounded_int_stack_assert.svh =====
// Assertion macros used by the bounded integer stack sequencer.
// Include by bare file name; needs a clock and an active-low reset in scope.
`ifndef BOUNDED_INT_STACK_ASSERT_SVH
`define BOUNDED_INT_STACK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BIS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bounded_int_stack: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BIS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bounded_int_stack: next-cycle check failed");

`endif

// ===== hw/rtl/bis_pkg.sv =====
// Package for the bounded integer stack: field widths, command and status
// codes, and the control word that the sequencer hands to the cell row.
package bis_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int CNT_O_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Per-cycle command to every cell of the row.
    typedef struct packed {
        logic push;       // every cell takes the word of the cell above it
        logic pop;        // every cell takes the word of the cell below it
        logic load_hit;   // every cell compares its word with the key
        logic shift_hit;  // match flags move one cell toward the top
    } t_cell_ctl;

endpackage

// ===== hw/rtl/bis_cell.sv =====
// One storage cell of the stack row: a data word and a match flag.
// Depends on bis_pkg for the control word type.
module bis_cell
    import bis_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_up_data,
    input  logic [DATA_WIDTH-1:0] i_down_data,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic                  i_down_hit,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic                  o_hit
);

    logic [DATA_WIDTH-1:0] r_entry;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_up_data;
        end else if (i_ctl.pop) begin
            r_entry <= i_down_data;
        end
        if (i_ctl.load_hit) begin
            r_hit <= (r_entry == i_key);
        end else if (i_ctl.shift_hit) begin
            r_hit <= i_down_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== hw/rtl/bis_ctrl.sv =====
// Sequencer of the bounded integer stack: count, capacity register, search
// walk and the registered result. Depends on bis_pkg and the assertion header.
`include "bounded_int_stack_assert.svh"

module bis_ctrl
    import bis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_command,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data,
    output logic [IDX_W-1:0]    o_found_index,
    output logic [CNT_O_W-1:0]  o_count,
    output logic                o_is_empty,
    output logic                o_is_full,
    output t_cell_ctl           o_ctl,
    input  logic [DATA_W-1:0]   i_top_entry,
    input  logic                i_top_hit
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_step, n_step;
    logic [CAP_W-1:0]    r_cap;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [IDX_W-1:0]    r_found, n_found;
    logic [CNT_O_W-1:0]  r_cnt_o, n_cnt_o;
    logic                r_empty, n_empty;
    logic                r_full, n_full;

    logic [CMP_W-1:0]    limit;
    logic                out_free;
    logic                accept;
    logic                push_ok;
    logic                full_now;
    logic                done;
    logic [STATUS_W-1:0] res_status;
    logic [DATA_W-1:0]   res_data;
    logic [IDX_W-1:0]    res_found;
    logic [CNT_W-1:0]    hit_idx;

    assign limit    = (CMP_W'(r_cap) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(r_cap);
    assign out_free = !r_out_valid || i_out_ready;
    assign full_now = CMP_W'(r_count) >= limit;
    assign accept   = i_in_valid && o_in_ready;
    assign push_ok  = accept && (i_command == CMD_PUSH) && !full_now;
    assign hit_idx  = r_count - r_step - CNT_W'(1);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_found     = r_found;
        n_cnt_o     = r_cnt_o;
        n_empty     = r_empty;
        n_full      = r_full;
        o_ctl       = '0;
        done        = 1'b0;
        res_status  = ST_OK;
        res_data    = '0;
        res_found   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    done = 1'b1;
                    case (i_command)
                        CMD_PUSH: begin
                            if (full_now) begin
                                res_status = ST_FULL;
                            end else begin
                                o_ctl.push = 1'b1;
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                res_status = ST_EMPTY;
                            end else begin
                                o_ctl.pop = 1'b1;
                                res_data  = i_top_entry;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count == '0) begin
                                res_status = ST_EMPTY;
                            end else begin
                                res_data = i_top_entry;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_SEARCH: begin
                            done           = 1'b0;
                            o_ctl.load_hit = 1'b1;
                            n_step         = '0;
                            n_state        = S_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // The flag of the entry at depth r_step below the top sits in the top cell.
                if (out_free) begin
                    if (r_step == r_count) begin
                        done       = 1'b1;
                        res_status = ST_NOTFOUND;
                        n_state    = S_IDLE;
                    end else if (i_top_hit) begin
                        done      = 1'b1;
                        res_found = IDX_W'(hit_idx);
                        n_state   = S_IDLE;
                    end else begin
                        o_ctl.shift_hit = 1'b1;
                        n_step          = r_step + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            n_out_valid = 1'b1;
            n_status    = res_status;
            n_data      = res_data;
            n_found     = res_found;
            n_cnt_o     = CNT_O_W'(n_count);
            n_empty     = (n_count == '0);
            n_full      = CMP_W'(n_count) >= limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
        r_cnt_o  <= n_cnt_o;
        r_empty  <= n_empty;
        r_full   <= n_full;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found_index = r_found;
    assign o_count       = r_cnt_o;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

    `BIS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `BIS_ASSERT_NOW(a_walk_bound, i_clk, i_rst_n, r_state == S_SEARCH, r_step <= r_count)
    `BIS_ASSERT_NOW(a_no_take_in_walk, i_clk, i_rst_n, r_state == S_SEARCH, !o_in_ready)
    `BIS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push_ok, r_count == $past(r_count) + CNT_W'(1))

endmodule

// ===== hw/rtl/bounded_int_stack.sv =====
// Top level of the bounded integer stack: a row of storage cells and its sequencer.
// Depends on bis_pkg, bis_cell and bis_ctrl.
//
// A last-in first-out stack of signed 32-bit words held in a row of DEPTH cells,
// with the top of the stack always in the first cell. A push shifts every word one
// cell down and a pop shifts every word one cell up, so push, pop, peek and clear
// each finish directly: a word is taken on the edge where the input handshake
// completes and its result word is registered on that same edge. A search latches a
// match flag in every cell at once, then moves the flags toward the first cell one
// position a cycle while the sequencer counts the steps; a miss is reported when the
// steps reach the count, a hit when the topmost match reaches the first cell. The
// input is not ready during a search, nor while an unread result holds the output
// register. The capacity register may be written at any idle time, resets to 16 and
// is clamped to DEPTH; lowering it keeps the stored words. Stored words need no reset.
module bounded_int_stack
    import bis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data,
    output logic [IDX_W-1:0]    o_found_index,
    output logic [CNT_O_W-1:0]  o_count,
    output logic                o_is_empty,
    output logic                o_is_full
);

    t_cell_ctl         ctl;
    logic [DATA_W-1:0] cell_entry [DEPTH];
    logic              cell_hit   [DEPTH];

    // Cell 0 is the top of the stack; pushed words enter there.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] up_data;
        logic [DATA_W-1:0] down_data;
        logic              down_hit;

        if (k == 0) begin : g_top
            assign up_data = i_value;
        end else begin : g_mid
            assign up_data = cell_entry[k-1];
        end

        // The bottom cell keeps its word on a pop and takes a cleared match flag from below.
        if (k == DEPTH - 1) begin : g_bottom
            assign down_data = cell_entry[k];
            assign down_hit  = 1'b0;
        end else begin : g_inner
            assign down_data = cell_entry[k+1];
            assign down_hit  = cell_hit[k+1];
        end

        bis_cell #(
            .DATA_WIDTH (DATA_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_up_data   (up_data),
            .i_down_data (down_data),
            .i_key       (i_value),
            .i_down_hit  (down_hit),
            .o_entry     (cell_entry[k]),
            .o_hit       (cell_hit[k])
        );
    end

    bis_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_ctl         (ctl),
        .i_top_entry   (cell_entry[0]),
        .i_top_hit     (cell_hit[0])
    );

endmodule
